### hw/rtl/sparse_csr_matvec_add_defines.svh
// Assertion macros for the sparse CSR matrix-vector block.
// No dependencies; included by the RTL files that carry assertions.
`ifndef SPARSE_CSR_MATVEC_ADD_DEFINES_SVH
`define SPARSE_CSR_MATVEC_ADD_DEFINES_SVH

// Same-cycle implication, disabled while reset is held.
`define SCMA_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is held.
`define SCMA_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### hw/rtl/scma_pkg.sv
// Types, field widths, mode codes and arithmetic helpers for the sparse
// CSR matrix-vector block. No dependencies.
`default_nettype none

package scma_pkg;

    localparam int unsigned INDEX_W = 10;
    localparam int unsigned DATA_W  = 32;
    localparam int unsigned ROW_W   = 16;
    localparam int unsigned MODE_W  = 2;
    localparam int unsigned SUM_W   = 64;
    localparam int unsigned TOT_W   = 53;   // y +/- scaled sum, never overflows

    typedef logic [MODE_W-1:0]        t_mode;
    typedef logic signed [SUM_W-1:0]  t_sum;
    typedef logic signed [DATA_W-1:0] t_data;
    typedef logic signed [TOT_W-1:0]  t_tot;

    localparam t_mode MODE_LOAD  = 2'd0;
    localparam t_mode MODE_NZ    = 2'd1;
    localparam t_mode MODE_EMPTY = 2'd2;
    localparam t_mode MODE_NONE  = 2'd3;

    localparam t_data SCALE_RESET = 32'sd65536;   // 1.0 in Q16.16
    localparam t_data DATA_MAX    = 32'sh7FFF_FFFF;
    localparam t_data DATA_MIN    = 32'sh8000_0000;

    // 64-bit add clamped to the signed limits
    function automatic t_sum sat_add_sum(input t_sum a, input t_sum b);
        logic signed [SUM_W:0] s;
        t_sum                  r;
        s = {a[SUM_W-1], a} + {b[SUM_W-1], b};
        if (s[SUM_W] != s[SUM_W-1]) begin
            r = s[SUM_W] ? {1'b1, {(SUM_W-1){1'b0}}} : {1'b0, {(SUM_W-1){1'b1}}};
        end else begin
            r = s[SUM_W-1:0];
        end
        return r;
    endfunction

    // clamp the wide total into Q16.16
    function automatic t_data clamp_data(input t_tot v);
        t_data r;
        if (!v[TOT_W-1] && (|v[TOT_W-2:DATA_W-1])) begin
            r = DATA_MAX;
        end else if (v[TOT_W-1] && !(&v[TOT_W-2:DATA_W-1])) begin
            r = DATA_MIN;
        end else begin
            r = v[DATA_W-1:0];
        end
        return r;
    endfunction

endpackage

`default_nettype wire

### hw/rtl/sparse_csr_matvec_add.sv
// Channel   | dir | handshake              | payload
// ----------+-----+------------------------+---------------------------------
// item in   | in  | i_in_valid / o_in_stall | i_mode i_index i_value i_row_last i_y_old
// result    | out | o_out_valid / i_out_stall | o_y_new o_row_number
// scale cfg | in  | i_scale_we             | i_scale_wdata
//
// One item at a time. Load and mode three are done in the idle state. Nonzero inside a row:
// x memory read, signed 32x32 multiply, saturating accumulate. Row end adds steps for
// magnitude, two passes of the shared 32x32 multiplier over the 64-bit sum, and the
// final add/clamp. Empty row goes straight to emit. Result stage stall adds its own
// wait at the last step. Synchronous active-low reset; no memory clear.
// Depends on scma_pkg and sparse_csr_matvec_add_defines.svh.
`default_nettype none
`include "sparse_csr_matvec_add_defines.svh"

module sparse_csr_matvec_add
    import scma_pkg::*;
#(
    parameter int unsigned X_DEPTH = 1024
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_scale_we,
    input  wire logic [DATA_W-1:0]     i_scale_wdata,
    input  wire logic                  i_in_valid,
    output logic                       o_in_stall,
    input  wire logic [MODE_W-1:0]     i_mode,
    input  wire logic [INDEX_W-1:0]    i_index,
    input  wire logic signed [DATA_W-1:0] i_value,
    input  wire logic                  i_row_last,
    input  wire logic signed [DATA_W-1:0] i_y_old,
    output logic                       o_out_valid,
    input  wire logic                  i_out_stall,
    output logic signed [DATA_W-1:0]   o_y_new,
    output logic [ROW_W-1:0]           o_row_number
);

    localparam int unsigned AW = (X_DEPTH > 1) ? $clog2(X_DEPTH) : 1;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_MUL  = 3'd1;
    localparam logic [2:0] S_ACC  = 3'd2;
    localparam logic [2:0] S_MAG  = 3'd3;
    localparam logic [2:0] S_P1   = 3'd4;
    localparam logic [2:0] S_P2   = 3'd5;
    localparam logic [2:0] S_FIN  = 3'd6;
    localparam logic [2:0] S_EMIT = 3'd7;

    // control state
    logic [2:0]        r_state, n_state;
    logic              r_out_valid;
    t_sum              r_row_sum;
    logic [ROW_W-1:0]  r_row_counter;
    t_data             r_scale;

    // payload
    logic [DATA_W-1:0] r_x_mem [X_DEPTH];
    logic [DATA_W-1:0] r_x_rd;
    logic              r_x_ok;
    t_data             r_value;
    t_data             r_y_old;
    logic              r_last;
    t_sum              r_prod;
    t_sum              r_sum_fin;
    logic [SUM_W-1:0]  r_ms;
    logic [DATA_W-1:0] r_mc;
    logic              r_neg;
    logic              r_zero;
    logic [SUM_W-1:0]  r_p1;
    logic [SUM_W-1:0]  r_p2;
    t_data             r_res;
    t_data             r_y_new;
    logic [ROW_W-1:0]  r_row_number;

    logic              w_in_acc;
    logic              w_out_free;
    logic              w_emit;
    logic              w_in_range;
    logic [AW-1:0]     w_addr;
    t_data             w_xop;
    t_sum              w_prod;
    t_sum              w_acc;
    logic [DATA_W-1:0] w_mul_a;
    logic [SUM_W-1:0]  w_umul;
    logic [TOT_W-2:0]  w_m;
    t_tot              w_y;
    t_tot              w_tot;
    t_data             w_fin;

    assign o_in_stall = (r_state != S_IDLE);
    assign w_in_acc   = i_in_valid && !o_in_stall;
    assign w_out_free = !r_out_valid || !i_out_stall;
    assign w_emit     = (r_state == S_EMIT) && w_out_free;
    assign w_in_range = (32'(i_index) < X_DEPTH);
    assign w_addr     = AW'(i_index);

    // x store: a read on every accepted beat, plus a write for an in-range load
    always_ff @(posedge i_clk) begin
        if (w_in_acc && (i_mode == MODE_LOAD) && w_in_range) begin
            r_x_mem[w_addr] <= i_value;
        end
        if (w_in_acc) begin
            r_x_rd <= r_x_mem[w_addr];
        end
    end

    // column out of range contributes x = 0
    assign w_xop  = r_x_ok ? t_data'(r_x_rd) : '0;
    assign w_prod = t_sum'(r_value) * t_sum'(w_xop);
    assign w_acc  = sat_add_sum(r_row_sum, r_prod >>> 16);

    // low then high half of |sum| times |scale|
    assign w_mul_a = (r_state == S_P1) ? r_ms[DATA_W-1:0] : r_ms[SUM_W-1:DATA_W];
    assign w_umul  = {32'd0, w_mul_a} * {32'd0, r_mc};

    assign w_m   = (TOT_W-1)'({r_p2[33:0], 16'd0}) + (TOT_W-1)'(r_p1[SUM_W-1:16]);
    assign w_y   = t_tot'(r_y_old);
    assign w_tot = r_neg ? (w_y - t_tot'({1'b0, w_m})) : (w_y + t_tot'({1'b0, w_m}));

    always_comb begin
        if (r_zero) begin
            w_fin = r_y_old;
        end else if (|r_p2[SUM_W-1:34]) begin
            w_fin = r_neg ? DATA_MIN : DATA_MAX;
        end else begin
            w_fin = clamp_data(w_tot);
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (w_in_acc) begin
                    unique case (i_mode)
                        MODE_NZ:    n_state = S_MUL;
                        MODE_EMPTY: n_state = S_EMIT;
                        MODE_LOAD:  n_state = S_IDLE;
                        MODE_NONE:  n_state = S_IDLE;
                    endcase
                end
            end
            S_MUL:  n_state = S_ACC;
            S_ACC:  n_state = r_last ? S_MAG : S_IDLE;
            S_MAG:  n_state = S_P1;
            S_P1:   n_state = S_P2;
            S_P2:   n_state = S_FIN;
            S_FIN:  n_state = S_EMIT;
            S_EMIT: n_state = w_out_free ? S_IDLE : S_EMIT;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_IDLE;
            r_out_valid   <= 1'b0;
            r_row_sum     <= '0;
            r_row_counter <= '0;
            r_scale       <= SCALE_RESET;
        end else begin
            r_state <= n_state;
            if (i_scale_we) begin
                r_scale <= i_scale_wdata;
            end
            if (w_emit) begin
                r_out_valid   <= 1'b1;
                r_row_counter <= r_row_counter + 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            if (w_in_acc && (i_mode == MODE_LOAD)) begin
                r_row_counter <= '0;
                r_row_sum     <= '0;
            end
            if (w_in_acc && (i_mode == MODE_EMPTY)) begin
                r_row_sum <= '0;
            end
            if (r_state == S_ACC) begin
                r_row_sum <= r_last ? '0 : w_acc;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_value <= i_value;
            r_y_old <= i_y_old;
            r_last  <= i_row_last;
            r_x_ok  <= w_in_range;
            r_res   <= i_y_old;     // empty row passes y through
        end
        if (r_state == S_MUL) begin
            r_prod <= w_prod;
        end
        if (r_state == S_ACC) begin
            r_sum_fin <= w_acc;
        end
        if (r_state == S_MAG) begin
            r_ms   <= r_sum_fin[SUM_W-1] ? SUM_W'(-r_sum_fin) : SUM_W'(r_sum_fin);
            r_mc   <= r_scale[DATA_W-1] ? DATA_W'(-r_scale) : DATA_W'(r_scale);
            r_neg  <= r_sum_fin[SUM_W-1] ^ r_scale[DATA_W-1];
            r_zero <= (r_sum_fin == '0) || (r_scale == '0);
        end
        if (r_state == S_P1) begin
            r_p1 <= w_umul;
        end
        if (r_state == S_P2) begin
            r_p2 <= w_umul;
        end
        if (r_state == S_FIN) begin
            r_res <= w_fin;
        end
        if (w_emit) begin
            r_y_new      <= r_res;
            r_row_number <= r_row_counter;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_y_new      = r_y_new;
    assign o_row_number = r_row_number;

    `SCMA_ASSERT_NEXT(a_nz_to_mul, i_clk, i_rst_n, w_in_acc && (i_mode == MODE_NZ), r_state == S_MUL, "nonzero beat did not start multiply")
    `SCMA_ASSERT_NEXT(a_empty_to_emit, i_clk, i_rst_n, w_in_acc && (i_mode == MODE_EMPTY), r_state == S_EMIT, "empty row did not go to emit")
    `SCMA_ASSERT_NEXT(a_emit_loads, i_clk, i_rst_n, w_emit, o_out_valid && (o_y_new == $past(r_res)), "result stage not loaded on emit")
    `SCMA_ASSERT_NEXT(a_row_step, i_clk, i_rst_n, w_emit, r_row_counter == ROW_W'($past(r_row_counter) + 1'b1), "row counter did not advance")

endmodule

`default_nettype wire

### sim/tb.sv
`timescale 1ns / 1ps
// Self-checking bench for sparse_csr_matvec_add: streams x loads, CSR rows and
// scale writes, and checks every y beat against a typed or in-bench Q16.16 prediction.
// Depends on scma_pkg and the block RTL.
module tb;
    import scma_pkg::*;

    typedef struct packed {
        t_mode              mode;
        logic [INDEX_W-1:0] idx;
        t_data              val;
        logic               last;
        t_data              y;
        logic               typed;
        t_data              ey;
        logic [ROW_W-1:0]   erow;
    } t_stim_row;

    typedef struct packed {
        t_data            y;
        logic [ROW_W-1:0] row;
    } t_y_upd;

    localparam int N_DIRECTED = 23;
    localparam int N_RANDOM   = 1700;

    // typed expectations only where the sum is plain to see
    localparam t_stim_row DIRECTED [N_DIRECTED] = '{
        '{MODE_EMPTY, 10'h000, 32'h0000_0000, 1'b0, 32'h7FFF_FFFF, 1'b1, 32'h7FFF_FFFF, 16'd0},
        '{MODE_EMPTY, 10'h3FF, 32'hFFFF_FFFF, 1'b1, 32'h8000_0000, 1'b1, 32'h8000_0000, 16'd1},
        '{MODE_NONE,  10'h2AA, 32'h5A5A_5A5A, 1'b1, 32'h1234_5678, 1'b0, 32'h0, 16'd0},
        '{MODE_LOAD,  10'h000, 32'h0001_0000, 1'b0, 32'h0000_0000, 1'b0, 32'h0, 16'd0},
        '{MODE_LOAD,  10'h3FF, 32'h7FFF_FFFF, 1'b0, 32'h0000_0000, 1'b0, 32'h0, 16'd0},
        '{MODE_LOAD,  10'h200, 32'h8000_0000, 1'b0, 32'h0000_0000, 1'b0, 32'h0, 16'd0},
        '{MODE_LOAD,  10'h155, 32'hFFFF_FFFF, 1'b0, 32'h0000_0000, 1'b0, 32'h0, 16'd0},
        '{MODE_LOAD,  10'h2AA, 32'h0002_8000, 1'b1, 32'hFFFF_FFFF, 1'b0, 32'h0, 16'd0},
        '{MODE_NZ,    10'h000, 32'h0002_0000, 1'b1, 32'h0001_0000, 1'b1, 32'h0003_0000, 16'd0},
        '{MODE_NZ,    10'h3FF, 32'h7FFF_FFFF, 1'b0, 32'h0000_0000, 1'b0, 32'h0, 16'd0},
        '{MODE_NZ,    10'h3FF, 32'h7FFF_FFFF, 1'b1, 32'h0000_0000, 1'b1, 32'h7FFF_FFFF, 16'd1},
        '{MODE_NZ,    10'h200, 32'h8000_0000, 1'b1, 32'h8000_0000, 1'b1, 32'h7FFF_FFFF, 16'd2},
        '{MODE_NZ,    10'h200, 32'h7FFF_FFFF, 1'b1, 32'h7FFF_FFFF, 1'b1, 32'h8000_0000, 16'd3},
        '{MODE_NZ,    10'h155, 32'h0000_0001, 1'b1, 32'h0000_0000, 1'b1, 32'hFFFF_FFFF, 16'd4},
        '{MODE_NZ,    10'h2AA, 32'h0001_0000, 1'b0, 32'h0000_0000, 1'b0, 32'h0, 16'd0},
        '{MODE_EMPTY, 10'h000, 32'h0000_0000, 1'b0, 32'h1234_5678, 1'b1, 32'h1234_5678, 16'd5},
        '{MODE_NZ,    10'h2AA, 32'h0001_0000, 1'b1, 32'h0000_0000, 1'b1, 32'h0002_8000, 16'd6},
        '{MODE_LOAD,  10'h001, 32'hDEAD_BEEF, 1'b1, 32'h0000_0000, 1'b0, 32'h0, 16'd0},
        '{MODE_NZ,    10'h001, 32'h0001_0000, 1'b1, 32'h0000_0000, 1'b1, 32'hDEAD_BEEF, 16'd0},
        '{MODE_NONE,  10'h000, 32'h0000_0000, 1'b0, 32'h0000_0000, 1'b0, 32'h0, 16'd0},
        '{MODE_NZ,    10'h000, 32'h0000_0000, 1'b1, 32'h7FFF_FFFF, 1'b1, 32'h7FFF_FFFF, 16'd1},
        '{MODE_NZ,    10'h155, 32'hFFFF_0000, 1'b0, 32'h0000_0000, 1'b0, 32'h0, 16'd0},
        '{MODE_NZ,    10'h000, 32'h8000_0000, 1'b1, 32'h0000_0000, 1'b0, 32'h0, 16'd0}
    };

    localparam t_data SCALE_SET [8] = '{
        SCALE_RESET, DATA_MAX, DATA_MIN, 32'sh0000_0000,
        32'shFFFF_0000, 32'sh0000_0001, 32'sh0000_8000, 32'sh0003_0000
    };

    logic               i_clk;
    logic               i_rst_n;
    logic               i_scale_we;
    logic [DATA_W-1:0]  i_scale_wdata;
    logic               i_in_valid;
    logic               o_in_stall;
    t_mode              i_mode;
    logic [INDEX_W-1:0] i_index;
    t_data              i_value;
    logic               i_row_last;
    t_data              i_y_old;
    logic               o_out_valid;
    logic               i_out_stall;
    t_data              o_y_new;
    logic [ROW_W-1:0]   o_row_number;

    // predictor state
    t_data            x_mem [0:1023];
    bit               x_seen [0:1023];
    int               seen_idx [$];
    t_sum             part_sum;
    logic [ROW_W-1:0] row_ctr;
    t_data            scale_q;
    t_y_upd           y_due [$];

    int n_mismatch = 0;
    int n_items    = 0;
    int n_rows     = 0;
    int n_scales   = 0;
    int calm_from  = 0;
    int idle_pct   = 0;
    bit calm       = 1'b0;

    sparse_csr_matvec_add uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_scale_we    (i_scale_we),
        .i_scale_wdata (i_scale_wdata),
        .i_in_valid    (i_in_valid),
        .o_in_stall    (o_in_stall),
        .i_mode        (i_mode),
        .i_index       (i_index),
        .i_value       (i_value),
        .i_row_last    (i_row_last),
        .i_y_old       (i_y_old),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_y_new       (o_y_new),
        .o_row_number  (o_row_number)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    task automatic flag_mismatch(input string msg);
        n_mismatch++;
        $display("[%0t] mismatch: %s", $time, msg);
    endtask

    // y + trunc(sum*scale / 2^16) on magnitudes, clamped to Q16.16
    function automatic t_data finish_y(input t_data y, input t_sum sum, input t_data s);
        logic [SUM_W-1:0]   ms;
        logic [DATA_W-1:0]  mc;
        logic [95:0]        full;
        logic signed [81:0] tot;
        ms   = sum[SUM_W-1] ? -sum : sum;
        mc   = s[DATA_W-1] ? -s : s;
        full = 96'(ms) * 96'(mc);
        tot  = $signed({2'b00, full[95:16]});
        if (sum[SUM_W-1] ^ s[DATA_W-1]) begin
            tot = -tot;
        end
        tot = tot + 82'(y);
        if (tot > DATA_MAX) begin
            return DATA_MAX;
        end
        if (tot < DATA_MIN) begin
            return DATA_MIN;
        end
        return tot[DATA_W-1:0];
    endfunction

    // advances the predictor by one accepted beat; returns 1 when a y beat is due
    function automatic bit step_y_update(input t_mode m, input logic [INDEX_W-1:0] idx,
                                         input t_data v, input logic last, input t_data y,
                                         output t_y_upd r);
        t_sum              a;
        t_sum              b;
        t_sum              prod;
        logic signed [SUM_W:0] wide;
        bit                hit;
        hit = 1'b0;
        r   = '0;
        case (m)
            MODE_LOAD: begin
                x_mem[idx] = v;
                if (!x_seen[idx]) begin
                    x_seen[idx] = 1'b1;
                    seen_idx.push_back(int'(idx));
                end
                row_ctr  = '0;
                part_sum = '0;
            end
            MODE_NZ: begin
                a    = t_sum'(v);
                b    = t_sum'(x_mem[idx]);
                prod = (a * b) >>> 16;
                wide = (SUM_W+1)'(part_sum) + (SUM_W+1)'(prod);
                if (wide[SUM_W] != wide[SUM_W-1]) begin
                    part_sum = wide[SUM_W] ? 64'sh8000_0000_0000_0000
                                           : 64'sh7FFF_FFFF_FFFF_FFFF;
                end else begin
                    part_sum = wide[SUM_W-1:0];
                end
                if (last) begin
                    r.y      = finish_y(y, part_sum, scale_q);
                    r.row    = row_ctr;
                    part_sum = '0;
                    row_ctr  = row_ctr + 1'b1;
                    hit      = 1'b1;
                end
            end
            MODE_EMPTY: begin
                r.y      = y;
                r.row    = row_ctr;
                part_sum = '0;
                row_ctr  = row_ctr + 1'b1;
                hit      = 1'b1;
            end
            default: ;
        endcase
        return hit;
    endfunction

    // drive one beat from the falling edge and hold it until taken
    task automatic push_item(input t_mode m, input logic [INDEX_W-1:0] idx, input t_data v,
                             input logic last, input t_data y, input logic typed,
                             input t_data ey, input logic [ROW_W-1:0] erow);
        t_y_upd r;
        @(negedge i_clk);
        if (!calm && idle_pct != 0 && $urandom_range(0, 99) < idle_pct) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 17)) @(negedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_mode     <= m;
        i_index    <= idx;
        i_value    <= v;
        i_row_last <= last;
        i_y_old    <= y;
        do @(posedge i_clk); while (o_in_stall);
        if (step_y_update(m, idx, v, last, y, r)) begin
            if (typed) begin
                r.y   = ey;
                r.row = erow;
            end
            y_due.push_back(r);
            n_rows++;
        end
        if (m != MODE_NONE) begin
            n_items++;
        end
    endtask

    // sender holds off until every y beat is back, then lets the pipe empty
    task automatic settle_results();
        int waited;
        waited = 0;
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (y_due.size() != 0 && waited < 20000) begin
            @(posedge i_clk);
            waited++;
        end
        repeat (16) @(posedge i_clk);
        if (y_due.size() != 0) begin
            flag_mismatch($sformatf("%0d y beats never arrived", y_due.size()));
            y_due.delete();
        end
    endtask

    task automatic write_scale(input t_data s);
        @(negedge i_clk);
        i_scale_we    <= 1'b1;
        i_scale_wdata <= s;
        @(negedge i_clk);
        i_scale_we <= 1'b0;
        scale_q = s;
        n_scales++;
    endtask

    function automatic t_data pick_word();
        case ($urandom_range(0, 15))
            0:          return '0;
            1:          return DATA_MAX;
            2:          return DATA_MIN;
            3:          return SCALE_RESET;
            4:          return '1;
            5:          return 32'sd1;
            6, 7, 8, 9: return $signed($urandom_range(0, 32'h0020_0000)) - 32'sh0010_0000;
            default:    return $urandom();
        endcase
    endfunction

    function automatic logic [INDEX_W-1:0] pick_index();
        case ($urandom_range(0, 7))
            0:       return '0;
            1:       return '1;
            default: return INDEX_W'($urandom_range(0, 1023));
        endcase
    endfunction

    // only columns already loaded since reset are ever read
    function automatic logic [INDEX_W-1:0] pick_column();
        return INDEX_W'(seen_idx[$urandom_range(0, seen_idx.size() - 1)]);
    endfunction

    task automatic random_phase(input int quota);
        int stop_at;
        int nnz;
        int k;
        bit broken;
        stop_at = n_items + quota;
        while (n_items < stop_at) begin
            if (n_items >= calm_from) begin
                calm     = 1'b1;
                idle_pct = 0;
            end
            k = $urandom_range(0, 99);
            if (seen_idx.size() == 0 || k < 12) begin
                repeat ($urandom_range(1, 8)) begin
                    push_item(MODE_LOAD, pick_index(), pick_word(), 1'($urandom),
                              pick_word(), 1'b0, '0, '0);
                end
            end else if (k < 17) begin
                push_item(MODE_NONE, INDEX_W'($urandom), pick_word(), 1'($urandom),
                          pick_word(), 1'b0, '0, '0);
            end else if (k < 27) begin
                push_item(MODE_EMPTY, INDEX_W'($urandom), pick_word(), 1'($urandom),
                          pick_word(), 1'b0, '0, '0);
            end else begin
                nnz    = ($urandom_range(0, 9) == 0) ? $urandom_range(7, 24)
                                                     : $urandom_range(1, 6);
                broken = ($urandom_range(0, 19) == 0);
                for (int j = 0; j < nnz; j++) begin
                    push_item(MODE_NZ, pick_column(), pick_word(),
                              !broken && (j == nnz - 1), pick_word(), 1'b0, '0, '0);
                end
            end
        end
    endtask

    always @(posedge i_clk) begin : y_check
        t_y_upd want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (y_due.size() == 0) begin
                flag_mismatch($sformatf("unexpected y beat row %0d", o_row_number));
            end else begin
                want = y_due.pop_front();
                if (o_y_new !== want.y) begin
                    flag_mismatch($sformatf("row %0d y_new %h, want %h",
                                            want.row, o_y_new, want.y));
                end
                if (o_row_number !== want.row) begin
                    flag_mismatch($sformatf("row_number %0d, want %0d",
                                            o_row_number, want.row));
                end
            end
        end
    end

    initial begin : result_stall
        i_out_stall = 1'b0;
        forever begin
            @(negedge i_clk);
            if (!calm && idle_pct != 0 && $urandom_range(0, 99) < idle_pct / 2 + 1) begin
                i_out_stall <= 1'b1;
                repeat ($urandom_range(0, 16)) @(negedge i_clk);
            end else begin
                i_out_stall <= 1'b0;
            end
        end
    end

    initial begin : run_limit
        #20_000_000;
        $display("run timed out");
        $display("CHECK FAILED");
        $finish;
    end

    initial begin : stimulus
        int    rand_target;
        int    n_phase;
        int    quota;
        t_data s;
        i_rst_n       = 1'b0;
        i_scale_we    = 1'b0;
        i_scale_wdata = '0;
        i_in_valid    = 1'b0;
        i_mode        = MODE_LOAD;
        i_index       = '0;
        i_value       = '0;
        i_row_last    = 1'b0;
        i_y_old       = '0;
        part_sum      = '0;
        row_ctr       = '0;
        scale_q       = SCALE_RESET;
        calm_from     = 32'h7FFF_FFFF;
        repeat (8) @(negedge i_clk);
        i_rst_n <= 1'b1;

        for (int i = 0; i < N_DIRECTED; i++) begin
            push_item(DIRECTED[i].mode, DIRECTED[i].idx, DIRECTED[i].val, DIRECTED[i].last,
                      DIRECTED[i].y, DIRECTED[i].typed, DIRECTED[i].ey, DIRECTED[i].erow);
        end
        settle_results();

        rand_target = n_items + N_RANDOM;
        calm_from   = n_items + N_RANDOM * 85 / 100;
        n_phase     = 0;
        while (n_items < rand_target) begin
            settle_results();
            if (n_phase < 8 || $urandom_range(0, 1) == 0) begin
                s = SCALE_SET[n_phase % 8];
            end else begin
                s = $urandom();
            end
            write_scale(s);
            case ($urandom_range(0, 3))
                0:       idle_pct = 0;
                1:       idle_pct = 5;
                2:       idle_pct = 20;
                default: idle_pct = 50;
            endcase
            quota = $urandom_range(60, 160);
            if (quota > rand_target - n_items) begin
                quota = rand_target - n_items;
            end
            random_phase(quota);
            n_phase++;
        end
        settle_results();

        $display("covered %0d beats, %0d y rows, %0d scale settings incl. both limits",
                 n_items, n_rows, n_scales);
        $display("%0d random phases with mixed idling, result stalls and broken rows",
                 n_phase);
        if (n_mismatch == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule

### sim.f
+incdir+hw/rtl
hw/rtl/scma_pkg.sv
hw/rtl/sparse_csr_matvec_add.sv
sim/tb.sv
